FILE: rtl/bfra_pkg.sv
// Shared types and codes of the best-fit region allocator.
package bfra_pkg;

   localparam int NUM_ENTRIES = 512;
   localparam int SIZE_BITS   = 40;

   localparam int SLOT_W  = 9;
   localparam int FIELD_W = 40;
   localparam int ALIGN_W = 32;
   localparam int BASE_W  = 48;
   localparam int PAGE_W  = 31;
   localparam int REFS_W  = 10;

   localparam logic [REFS_W-1:0] REFS_MAX = 10'd1023;

   localparam logic [2:0] ST_REUSED    = 3'd0;
   localparam logic [2:0] ST_NEW       = 3'd1;
   localparam logic [2:0] ST_ALIGN0    = 3'd2;
   localparam logic [2:0] ST_NO_SLOT   = 3'd3;
   localparam logic [2:0] ST_NO_REGION = 3'd4;
   localparam logic [2:0] ST_FREED     = 3'd5;
   localparam logic [2:0] ST_TOO_LARGE = 3'd6;

   localparam logic OP_RESERVE = 1'b0;
   localparam logic OP_FREE    = 1'b1;

   localparam logic CSR_SMALL_PAGE = 1'b0;
   localparam logic CSR_HUGE_PAGE  = 1'b1;

   typedef struct packed {
      logic                operation;
      logic [FIELD_W-1:0]  req_size;
      logic [ALIGN_W-1:0]  req_align;
      logic [1:0]          req_flags;
      logic [BASE_W-1:0]   region_base;
      logic [SLOT_W-1:0]   slot_to_free;
   } req_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [SLOT_W-1:0]   slot_index;
      logic [SLOT_W-1:0]   region_index;
      logic [FIELD_W-1:0]  block_offset;
      logic [FIELD_W-1:0]  region_bytes;
      logic                region_released;
      logic                huge_region;
   } rsp_type;

endpackage

FILE: rtl/bfra_rem_unit.sv
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
module bfra_rem_unit #(
   parameter int DW = 50
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [DW-1:0]                   dividend,
   input  logic [bfra_pkg::ALIGN_W-1:0]    divisor,
   output logic                            done,
   output logic [bfra_pkg::ALIGN_W-1:0]    rem
);
   localparam int CNT_W = $clog2(DW + 1);
   localparam int AW    = bfra_pkg::ALIGN_W;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DW-1:0]     quo_ff, quo_in;
   logic [AW-1:0]     rem_ff, rem_in;
   logic [AW-1:0]     div_ff, div_in;
   logic [AW:0]       trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, quo_ff[DW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DW);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = AW'(trial - {1'b0, div_ff});
         end else begin
            rem_in = AW'(trial);
         end
         quo_in = {quo_ff[DW-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

FILE: rtl/bfra_core.sv
// Allocator sequencer with the region and slot tables.
module bfra_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  bfra_pkg::req_type             in_item,
   input  logic [bfra_pkg::PAGE_W-1:0]   small_page,
   input  logic [bfra_pkg::PAGE_W-1:0]   huge_page,
   output logic                          res_valid,
   input  logic                          res_ready,
   output bfra_pkg::rsp_type             res_item
);
   localparam int NUM_ENTRIES = bfra_pkg::NUM_ENTRIES;
   localparam int SIZE_BITS   = bfra_pkg::SIZE_BITS;
   localparam int IW  = $clog2(NUM_ENTRIES);
   localparam int CW  = $clog2(NUM_ENTRIES + 1);
   localparam int SB  = SIZE_BITS;
   localparam int AW  = (SB > 48 ? SB : 48) + 2;
   localparam int RFW = bfra_pkg::REFS_W;
   localparam int LW  = bfra_pkg::ALIGN_W;
   localparam logic [AW-1:0] SIZE_MAX = (AW'(1) << SB) - AW'(1);
   localparam logic [CW-1:0] LAST_IDX = CW'(NUM_ENTRIES - 1);

   typedef struct packed {
      logic            valid;
      logic [1:0]      flags;
      logic [SB-1:0]   size;
      logic [SB-1:0]   used;
      logic [SB-1:0]   free_bytes;
      logic [RFW-1:0]  refs;
      logic            huge;
   } region_type;

   typedef struct packed {
      logic            valid;
      logic [IW-1:0]   region;
   } slot_type;

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_PAD  = 4'd2;
   localparam logic [3:0] S_RD   = 4'd3;
   localparam logic [3:0] S_CHK  = 4'd4;
   localparam logic [3:0] S_DIV  = 4'd5;
   localparam logic [3:0] S_END  = 4'd6;
   localparam logic [3:0] S_HUGE = 4'd7;
   localparam logic [3:0] S_OFF  = 4'd8;
   localparam logic [3:0] S_FRD1 = 4'd9;
   localparam logic [3:0] S_FRD2 = 4'd10;
   localparam logic [3:0] S_OUT  = 4'd11;

   region_type region_mem [NUM_ENTRIES];
   slot_type   slot_mem [NUM_ENTRIES];

   logic [3:0]         state_ff, state_in;
   logic [CW-1:0]      idx_ff, idx_in;
   bfra_pkg::req_type  item_ff, item_in;
   logic [AW-1:0]      padded_ff, padded_in;
   logic               found_ff, found_in;
   logic [IW-1:0]      best_idx_ff, best_idx_in;
   logic [AW-1:0]      best_tail_ff, best_tail_in;
   logic [AW-1:0]      pick_off_ff, pick_off_in;
   region_type         best_rec_ff, best_rec_in;
   logic               slot_found_ff, slot_found_in;
   logic [IW-1:0]      slot_sel_ff, slot_sel_in;
   logic               reg_found_ff, reg_found_in;
   logic [IW-1:0]      reg_sel_ff, reg_sel_in;
   logic               huge_ff, huge_in;
   logic [AW-1:0]      rsize_ff, rsize_in;
   bfra_pkg::rsp_type  res_ff, res_in;

   region_type         rrd_ff;
   slot_type           srd_ff;
   logic               r_re, s_re, r_we, s_we;
   logic [IW-1:0]      r_raddr, s_raddr, r_waddr, s_waddr;
   region_type         r_wdata;
   slot_type           s_wdata;

   logic               rem_start, rem_done;
   logic [AW-1:0]      rem_a;
   logic [LW-1:0]      rem_d, rem_r;
   logic [LW-1:0]      align_pad;
   logic [AW-1:0]      aoff, tail, step, sum_off;
   logic               last;
   logic [RFW-1:0]     refs_dec;

   bfra_rem_unit #(.DW(AW)) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (rem_a),
      .divisor  (rem_d),
      .done     (rem_done),
      .rem      (rem_r)
   );

   // distance to the next multiple of the alignment
   assign align_pad = (rem_r == '0) ? '0 : item_ff.req_align - rem_r;
   assign last      = (idx_ff == LAST_IDX);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      item_in       = item_ff;
      padded_in     = padded_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_tail_in  = best_tail_ff;
      pick_off_in   = pick_off_ff;
      best_rec_in   = best_rec_ff;
      slot_found_in = slot_found_ff;
      slot_sel_in   = slot_sel_ff;
      reg_found_in  = reg_found_ff;
      reg_sel_in    = reg_sel_ff;
      huge_in       = huge_ff;
      rsize_in      = rsize_ff;
      res_in        = res_ff;
      r_re = 1'b0; s_re = 1'b0; r_we = 1'b0; s_we = 1'b0;
      r_raddr = idx_ff[IW-1:0];
      s_raddr = idx_ff[IW-1:0];
      r_waddr = idx_ff[IW-1:0];
      s_waddr = idx_ff[IW-1:0];
      r_wdata = '0;
      s_wdata = '0;
      rem_start = 1'b0;
      rem_a     = AW'(small_page);
      rem_d     = item_ff.req_align;
      aoff      = AW'(rrd_ff.used) + AW'(align_pad);
      tail      = AW'(rrd_ff.size) - aoff;
      sum_off   = pick_off_ff + AW'(item_ff.req_size);
      step      = sum_off - AW'(best_rec_ff.used);
      refs_dec  = rrd_ff.refs - RFW'(1);

      unique case (state_ff)
         S_CLR: begin
            r_we = 1'b1;
            s_we = 1'b1;
            if (last) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         S_IDLE: begin
            if (in_valid) begin
               item_in = in_item;
               res_in  = '0;
               if (in_item.operation == bfra_pkg::OP_FREE) begin
                  res_in.status     = bfra_pkg::ST_FREED;
                  res_in.slot_index = in_item.slot_to_free;
                  if (32'(in_item.slot_to_free) >= NUM_ENTRIES) begin
                     state_in = S_OUT;
                  end else begin
                     s_re     = 1'b1;
                     s_raddr  = IW'(in_item.slot_to_free);
                     state_in = S_FRD1;
                  end
               end else if (in_item.req_align == '0) begin
                  res_in.status = bfra_pkg::ST_ALIGN0;
                  state_in      = S_OUT;
               end else begin
                  rem_start = 1'b1;
                  rem_a     = AW'(small_page);
                  rem_d     = in_item.req_align;
                  state_in  = S_PAD;
               end
            end
         end
         S_PAD: begin
            if (rem_done) begin
               padded_in = AW'(item_ff.req_size) + AW'(align_pad);
               if (padded_in > SIZE_MAX) begin
                  res_in.status = bfra_pkg::ST_TOO_LARGE;
                  state_in      = S_OUT;
               end else begin
                  idx_in        = '0;
                  found_in      = 1'b0;
                  slot_found_in = 1'b0;
                  reg_found_in  = 1'b0;
                  state_in      = S_RD;
               end
            end
         end
         S_RD: begin
            r_re     = 1'b1;
            s_re     = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (!srd_ff.valid && !slot_found_ff) begin
               slot_found_in = 1'b1;
               slot_sel_in   = idx_ff[IW-1:0];
            end
            if (!rrd_ff.valid && !reg_found_ff) begin
               reg_found_in = 1'b1;
               reg_sel_in   = idx_ff[IW-1:0];
            end
            if (rrd_ff.valid && rrd_ff.free_bytes != '0
                && rrd_ff.flags == item_ff.req_flags) begin
               rem_start = 1'b1;
               rem_a     = AW'(rrd_ff.used);
               state_in  = S_DIV;
            end else if (last) begin
               state_in = S_END;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_RD;
            end
         end
         S_DIV: begin
            if (rem_done) begin
               if (aoff <= AW'(rrd_ff.size) && AW'(item_ff.req_size) <= tail
                   && (!found_ff || tail < best_tail_ff)) begin
                  found_in     = 1'b1;
                  best_idx_in  = idx_ff[IW-1:0];
                  best_tail_in = tail;
                  pick_off_in  = aoff;
                  best_rec_in  = rrd_ff;
               end
               if (last) begin
                  state_in = S_END;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_RD;
               end
            end
         end
         S_END: begin
            priority if (!slot_found_ff) begin
               res_in.status = bfra_pkg::ST_NO_SLOT;
               state_in      = S_OUT;
            end else if (found_ff) begin
               r_we    = 1'b1;
               r_waddr = best_idx_ff;
               r_wdata = best_rec_ff;
               r_wdata.used = SB'(sum_off);
               r_wdata.free_bytes = (step > AW'(best_rec_ff.free_bytes)) ? '0 :
                                    SB'(AW'(best_rec_ff.free_bytes) - step);
               if (best_rec_ff.refs < bfra_pkg::REFS_MAX) begin
                  r_wdata.refs = best_rec_ff.refs + RFW'(1);
               end
               s_we    = 1'b1;
               s_waddr = slot_sel_ff;
               s_wdata = '{valid: 1'b1, region: best_idx_ff};
               res_in.status       = bfra_pkg::ST_REUSED;
               res_in.slot_index   = bfra_pkg::SLOT_W'(slot_sel_ff);
               res_in.region_index = bfra_pkg::SLOT_W'(best_idx_ff);
               res_in.block_offset = bfra_pkg::FIELD_W'(pick_off_ff);
               res_in.region_bytes = bfra_pkg::FIELD_W'(best_rec_ff.size);
               res_in.huge_region  = best_rec_ff.huge;
               state_in = S_OUT;
            end else if (!reg_found_ff) begin
               res_in.status = bfra_pkg::ST_NO_REGION;
               state_in      = S_OUT;
            end else begin
               huge_in  = huge_page != '0 && padded_ff > AW'(small_page)
                          && !item_ff.req_flags[0];
               rsize_in = padded_ff;
               rem_start = 1'b1;
               if (huge_in) begin
                  rem_a    = padded_ff;
                  rem_d    = LW'(huge_page);
                  state_in = S_HUGE;
               end else begin
                  rem_a    = AW'(item_ff.region_base);
                  state_in = S_OFF;
               end
            end
         end
         S_HUGE: begin
            if (rem_done) begin
               rsize_in = padded_ff + ((rem_r == '0) ? '0 :
                          AW'(LW'(huge_page) - rem_r));
               if (rsize_in > SIZE_MAX) begin
                  res_in.status = bfra_pkg::ST_TOO_LARGE;
                  state_in      = S_OUT;
               end else begin
                  rem_start = 1'b1;
                  rem_a     = AW'(item_ff.region_base);
                  state_in  = S_OFF;
               end
            end
         end
         S_OFF: begin
            if (rem_done) begin
               r_we    = 1'b1;
               r_waddr = reg_sel_ff;
               r_wdata.valid      = 1'b1;
               r_wdata.flags      = item_ff.req_flags;
               r_wdata.size       = SB'(rsize_ff);
               r_wdata.used       = SB'(padded_ff);
               r_wdata.free_bytes = SB'(rsize_ff - padded_ff);
               r_wdata.refs       = RFW'(1);
               r_wdata.huge       = huge_ff;
               s_we    = 1'b1;
               s_waddr = slot_sel_ff;
               s_wdata = '{valid: 1'b1, region: reg_sel_ff};
               res_in.status       = bfra_pkg::ST_NEW;
               res_in.slot_index   = bfra_pkg::SLOT_W'(slot_sel_ff);
               res_in.region_index = bfra_pkg::SLOT_W'(reg_sel_ff);
               res_in.block_offset = bfra_pkg::FIELD_W'(align_pad);
               res_in.region_bytes = bfra_pkg::FIELD_W'(rsize_ff);
               res_in.huge_region  = huge_ff;
               state_in = S_OUT;
            end
         end
         S_FRD1: begin
            if (!srd_ff.valid) begin
               state_in = S_OUT;
            end else begin
               r_re     = 1'b1;
               r_raddr  = srd_ff.region;
               state_in = S_FRD2;
            end
         end
         S_FRD2: begin
            s_we    = 1'b1;
            s_waddr = IW'(item_ff.slot_to_free);
            res_in.region_index = bfra_pkg::SLOT_W'(srd_ff.region);
            res_in.region_bytes = bfra_pkg::FIELD_W'(rrd_ff.size);
            res_in.huge_region  = rrd_ff.huge;
            r_waddr = srd_ff.region;
            if (rrd_ff.refs != '0) begin
               r_we = 1'b1;
               if (refs_dec == '0) begin
                  res_in.region_released = 1'b1;
               end else begin
                  r_wdata      = rrd_ff;
                  r_wdata.refs = refs_dec;
               end
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
      item_ff       <= item_in;
      padded_ff     <= padded_in;
      found_ff      <= found_in;
      best_idx_ff   <= best_idx_in;
      best_tail_ff  <= best_tail_in;
      pick_off_ff   <= pick_off_in;
      best_rec_ff   <= best_rec_in;
      slot_found_ff <= slot_found_in;
      slot_sel_ff   <= slot_sel_in;
      reg_found_ff  <= reg_found_in;
      reg_sel_ff    <= reg_sel_in;
      huge_ff       <= huge_in;
      rsize_ff      <= rsize_in;
      res_ff        <= res_in;
   end

   always_ff @(posedge clock) begin
      if (r_we) begin
         region_mem[r_waddr] <= r_wdata;
      end
      if (r_re) begin
         rrd_ff <= region_mem[r_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         slot_mem[s_waddr] <= s_wdata;
      end
      if (s_re) begin
         srd_ff <= slot_mem[s_raddr];
      end
   end

   assign in_ready  = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_OUT);
   assign res_item  = res_ff;

endmodule

FILE: rtl/best_fit_region_allocator_unit.sv
// Top level of the best-fit region allocator: ports, config registers, output register.
//
// Request words enter on req_*; req_tuser is the operation (0 reserve, 1 free).
// One response word per request leaves on rsp_*; rsp_tuser is the status code.
// csr_we writes small_page_size (index 0) or huge_page_size (index 1).
// After reset a clearing pass over all NUM_ENTRIES entries zeroes the region and slot
// tables; req_tready stays low during it. Config writes are taken at any time.
// One request is worked on at a time. A free of a valid slot reads the slot entry,
// then its region entry, and updates both. A reserve scans every entry, reading and
// checking each, and runs the bit-serial remainder unit once for the padding, once
// per matching region, and up to twice more when a region is opened. The remainder
// unit and the entry-by-entry table scan set how long a reserve takes.
// The response sits in an output register; the next request is accepted while
// it waits, and a stalled receiver only holds back the request after that.
module best_fit_region_allocator_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // req_size[39:0], req_align[71:40], req_flags[73:72], region_base[121:74],
   // slot_to_free[130:122], zero fill
   input  logic [135:0]  req_tdata,
   // operation
   input  logic          req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // slot_index[8:0], region_index[17:9], block_offset[57:18],
   // region_bytes[97:58], region_released[98], huge_region[99], zero fill
   output logic [103:0]  rsp_tdata,
   // status
   output logic [2:0]    rsp_tuser,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [30:0]   csr_wdata
);
   logic [30:0]        small_ff, huge_ff;
   logic               out_valid_ff, out_valid_in;
   bfra_pkg::rsp_type  out_ff, out_in;
   bfra_pkg::req_type  item;
   bfra_pkg::rsp_type  core_res;
   logic               core_valid, out_ready;

   assign item.operation    = req_tuser;
   assign item.req_size     = req_tdata[39:0];
   assign item.req_align    = req_tdata[71:40];
   assign item.req_flags    = req_tdata[73:72];
   assign item.region_base  = req_tdata[121:74];
   assign item.slot_to_free = req_tdata[130:122];

   assign out_ready = !out_valid_ff || rsp_tready;

   bfra_core u_core (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (item),
      .small_page (small_ff),
      .huge_page  (huge_ff),
      .res_valid  (core_valid),
      .res_ready  (out_ready),
      .res_item   (core_res)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_ready) begin
         out_valid_in = core_valid;
         out_in       = core_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         small_ff     <= 31'd4096;
         huge_ff      <= 31'd2097152;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (csr_we && csr_index == bfra_pkg::CSR_SMALL_PAGE) begin
            small_ff <= csr_wdata;
         end
         if (csr_we && csr_index == bfra_pkg::CSR_HUGE_PAGE) begin
            huge_ff <= csr_wdata;
         end
      end
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {4'b0, out_ff.huge_region, out_ff.region_released,
                        out_ff.region_bytes, out_ff.block_offset,
                        out_ff.region_index, out_ff.slot_index};

   a_release_only_on_free: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_ff.region_released |-> out_ff.status == bfra_pkg::ST_FREED)
      else $error("region release reported outside a free");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (out_ff.status == bfra_pkg::ST_ALIGN0
                     || out_ff.status == bfra_pkg::ST_NO_SLOT
                     || out_ff.status == bfra_pkg::ST_NO_REGION
                     || out_ff.status == bfra_pkg::ST_TOO_LARGE)
      |-> rsp_tdata == '0)
      else $error("error response carries nonzero fields");

   a_no_accept_while_core_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request accepted while one is in work");

endmodule

FILE: tb/tb_best_fit_region_allocator_unit.sv
// Testbench for best_fit_region_allocator_unit: directed table, random traffic, own predictor.
module tb_best_fit_region_allocator_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N = bfra_pkg::NUM_ENTRIES;
   localparam logic [63:0] SIZE_LIMIT = (64'd1 << 40) - 64'd1;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [135:0]  req_tdata = '0;
   logic          req_tuser = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [103:0]  rsp_tdata;
   logic [2:0]    rsp_tuser;
   logic          csr_we = 1'b0;
   logic          csr_index = 1'b0;
   logic [30:0]   csr_wdata = '0;

   best_fit_region_allocator_unit dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #400_000_000;
      $display("tb_best_fit_region_allocator_unit: done, errors");
      $finish;
   end

   // predictor state
   logic        rg_valid [N];
   logic [1:0]  rg_flags [N];
   logic [63:0] rg_size  [N];
   logic [63:0] rg_used  [N];
   logic [63:0] rg_free  [N];
   logic [9:0]  rg_refs  [N];
   logic        rg_huge  [N];
   logic        sl_valid [N];
   logic [8:0]  sl_region[N];
   logic [63:0] small_page = 64'd4096;
   logic [63:0] huge_page  = 64'd2097152;

   bfra_pkg::rsp_type pending_rsp[$];
   int      fail_count = 0;

   function automatic logic [63:0] round_to(logic [63:0] x, logic [63:0] a);
      return ((x + a - 64'd1) / a) * a;
   endfunction

   function automatic bfra_pkg::rsp_type status_only(logic [2:0] st);
      bfra_pkg::rsp_type r;
      r = '0;
      r.status = st;
      return r;
   endfunction

   function automatic bfra_pkg::rsp_type allocate(bfra_pkg::req_type q);
      bfra_pkg::rsp_type r;
      logic [63:0] size, align, padded, best_tail, pick_off, aoff, tail, rsize, stp;
      logic        found, huge;
      int          best, slot, reg_i, s, ri;
      r = '0;
      size = 64'(q.req_size);
      align = 64'(q.req_align);
      found = 1'b0;
      best = 0;
      best_tail = '0;
      pick_off = '0;
      if (q.operation == bfra_pkg::OP_FREE) begin
         s = q.slot_to_free;
         r.status = bfra_pkg::ST_FREED;
         r.slot_index = q.slot_to_free;
         if (!sl_valid[s]) return r;
         ri = sl_region[s];
         sl_valid[s] = 1'b0;
         sl_region[s] = '0;
         r.region_index = 9'(ri);
         r.region_bytes = rg_size[ri][39:0];
         r.huge_region = rg_huge[ri];
         if (rg_refs[ri] != '0) begin
            rg_refs[ri] = rg_refs[ri] - 10'd1;
            if (rg_refs[ri] == '0) begin
               r.region_released = 1'b1;
               rg_valid[ri] = '0; rg_flags[ri] = '0; rg_size[ri] = '0;
               rg_used[ri] = '0; rg_free[ri] = '0; rg_huge[ri] = '0;
            end
         end
         return r;
      end
      if (align == '0) return status_only(bfra_pkg::ST_ALIGN0);
      padded = size + (round_to(small_page, align) - small_page);
      if (padded > SIZE_LIMIT) return status_only(bfra_pkg::ST_TOO_LARGE);
      for (int i = 0; i < N; i++) begin
         if (!rg_valid[i] || rg_free[i] == '0 || rg_flags[i] != q.req_flags) continue;
         aoff = round_to(rg_used[i], align);
         if (aoff > rg_size[i]) continue;
         tail = rg_size[i] - aoff;
         if (size <= tail && (!found || tail < best_tail)) begin
            found = 1'b1;
            best = i;
            best_tail = tail;
            pick_off = aoff;
         end
      end
      for (slot = 0; slot < N; slot++) if (!sl_valid[slot]) break;
      if (slot >= N) return status_only(bfra_pkg::ST_NO_SLOT);
      if (found) begin
         stp = pick_off + size - rg_used[best];
         rg_used[best] = rg_used[best] + stp;
         rg_free[best] = (stp > rg_free[best]) ? 64'd0 : rg_free[best] - stp;
         if (rg_refs[best] < bfra_pkg::REFS_MAX) rg_refs[best] = rg_refs[best] + 10'd1;
         sl_valid[slot] = 1'b1;
         sl_region[slot] = 9'(best);
         r.status = bfra_pkg::ST_REUSED;
         r.slot_index = 9'(slot);
         r.region_index = 9'(best);
         r.block_offset = pick_off[39:0];
         r.region_bytes = rg_size[best][39:0];
         r.huge_region = rg_huge[best];
         return r;
      end
      for (reg_i = 0; reg_i < N; reg_i++) if (!rg_valid[reg_i]) break;
      if (reg_i >= N) return status_only(bfra_pkg::ST_NO_REGION);
      huge = huge_page != '0 && padded > small_page && !q.req_flags[0];
      rsize = huge ? round_to(padded, huge_page) : padded;
      if (rsize > SIZE_LIMIT) return status_only(bfra_pkg::ST_TOO_LARGE);
      rg_valid[reg_i] = 1'b1;
      rg_flags[reg_i] = q.req_flags;
      rg_size[reg_i] = rsize;
      rg_used[reg_i] = padded;
      rg_free[reg_i] = rsize - padded;
      rg_refs[reg_i] = 10'd1;
      rg_huge[reg_i] = huge;
      sl_valid[slot] = 1'b1;
      sl_region[slot] = 9'(reg_i);
      r.status = bfra_pkg::ST_NEW;
      r.slot_index = 9'(slot);
      r.region_index = 9'(reg_i);
      r.block_offset = 40'(round_to(64'(q.region_base), align) - 64'(q.region_base));
      r.region_bytes = rsize[39:0];
      r.huge_region = huge;
      return r;
   endfunction

   // response checker
   always @(posedge clock) begin
      bfra_pkg::rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status          = rsp_tuser;
         got.slot_index      = rsp_tdata[8:0];
         got.region_index    = rsp_tdata[17:9];
         got.block_offset    = rsp_tdata[57:18];
         got.region_bytes    = rsp_tdata[97:58];
         got.region_released = rsp_tdata[98];
         got.huge_region     = rsp_tdata[99];
         if (pending_rsp.size() == 0) begin
            if (fail_count < 10) $display("unexpected word: %p", got);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want) begin
               if (fail_count < 10) $display("mismatch: exp %p got %p", want, got);
               fail_count++;
            end
         end
      end
   end

   // receiver stalls: mostly short, a few long, some stretches always ready
   initial begin
      int n;
      forever begin
         @(negedge clock);
         rsp_tready = 1'b1;
         n = $urandom_range(0, 99);
         if (n < 30) repeat ($urandom_range(0, 40)) @(negedge clock);
         else if (n < 95) repeat ($urandom_range(0, 3)) @(negedge clock);
         else repeat ($urandom_range(50, 300)) @(negedge clock);
         rsp_tready = 1'b0;
         n = $urandom_range(0, 99);
         if (n < 85) repeat ($urandom_range(0, 3)) @(negedge clock);
         else repeat ($urandom_range(20, 200)) @(negedge clock);
      end
   end

   // drive one word; req_tvalid stays high into the next word when there is no gap
   task automatic send_word(bfra_pkg::req_type q, logic typed, bfra_pkg::rsp_type typed_rsp);
      bfra_pkg::rsp_type p;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser = q.operation;
      req_tdata = {5'b0, q.slot_to_free, q.region_base, q.req_flags, q.req_align, q.req_size};
      do @(posedge clock); while (!req_tready);
      p = allocate(q);
      pending_rsp.push_back(typed ? typed_rsp : p);
      if ($urandom_range(0, 99) < 40) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         if ($urandom_range(0, 19) == 0) repeat ($urandom_range(20, 150)) @(negedge clock);
         else repeat ($urandom_range(0, 3)) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [30:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == bfra_pkg::CSR_SMALL_PAGE) small_page = 64'(value);
      else huge_page = 64'(value);
   endtask

   function automatic bfra_pkg::req_type mk(logic op, logic [39:0] size, logic [31:0] align,
                                  logic [1:0] flags, logic [47:0] base, logic [8:0] slot);
      bfra_pkg::req_type q;
      q.operation = op; q.req_size = size; q.req_align = align;
      q.req_flags = flags; q.region_base = base; q.slot_to_free = slot;
      return q;
   endfunction

   function automatic int pick_live_slot();
      int s;
      s = $urandom_range(0, N - 1);
      for (int k = 0; k < N; k++) if (sl_valid[(s + k) % N]) return (s + k) % N;
      return -1;
   endfunction

   function automatic int live_count();
      int c = 0;
      for (int k = 0; k < N; k++) c += sl_valid[k];
      return c;
   endfunction

   function automatic bfra_pkg::req_type random_word();
      logic [31:0] align;
      logic [39:0] size;
      int n, s;
      n = $urandom_range(0, 99);
      align = 32'd1 << $urandom_range(0, 13);
      if ($urandom_range(0, 9) == 0) align = $urandom;
      size = 40'($urandom_range(0, 9000));
      if ($urandom_range(0, 29) == 0) size = {8'($urandom), 32'($urandom)};
      if (n < 3) align = '0;
      s = pick_live_slot();
      if ((n >= 55 || live_count() > 40) && s >= 0 && n >= 10)
         return mk(bfra_pkg::OP_FREE, {8'($urandom), 32'($urandom)}, $urandom,
                   2'($urandom), {16'($urandom), 32'($urandom)}, 9'(s));
      if (n >= 3 && n < 8)
         return mk(bfra_pkg::OP_FREE, {8'($urandom), 32'($urandom)}, $urandom,
                   2'($urandom), {16'($urandom), 32'($urandom)}, 9'($urandom));
      return mk(bfra_pkg::OP_RESERVE, size, align, 2'($urandom),
                {16'($urandom), 32'($urandom)}, 9'($urandom));
   endfunction

   task automatic free_all();
      int s;
      s = pick_live_slot();
      while (s >= 0) begin
         send_word(mk(bfra_pkg::OP_FREE, '0, '0, '0, '0, 9'(s)), 1'b0, '0);
         s = pick_live_slot();
      end
   endtask

   initial begin
      bfra_pkg::req_type q;
      bfra_pkg::req_type dir_req[$];
      logic    dir_typed[$];
      bfra_pkg::rsp_type dir_rsp[$];
      bfra_pkg::rsp_type freed0;
      logic [30:0] small_set[4];
      logic [30:0] huge_set[4];
      for (int i = 0; i < N; i++) begin
         rg_valid[i] = '0; rg_flags[i] = '0; rg_size[i] = '0; rg_used[i] = '0;
         rg_free[i] = '0; rg_refs[i] = '0; rg_huge[i] = '0;
         sl_valid[i] = '0; sl_region[i] = '0;
      end
      small_set = '{31'd1, 31'd1073741824, 31'd512, 31'd4096};
      huge_set  = '{31'd0, 31'd1073741824, 31'd1, 31'd2097152};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows
      freed0 = status_only(bfra_pkg::ST_FREED);
      dir_req.push_back(mk(bfra_pkg::OP_FREE, '0, '0, '0, '0, 9'd0));
      dir_typed.push_back(1'b1); dir_rsp.push_back(freed0);
      dir_req.push_back(mk(bfra_pkg::OP_RESERVE, 40'd100, 32'd0, 2'd0, 48'd0, 9'd0));
      dir_typed.push_back(1'b1); dir_rsp.push_back(status_only(bfra_pkg::ST_ALIGN0));
      dir_req.push_back(mk(bfra_pkg::OP_RESERVE, '1, 32'd8192, 2'd1, 48'd0, 9'd0));
      dir_typed.push_back(1'b1); dir_rsp.push_back(status_only(bfra_pkg::ST_TOO_LARGE));
      dir_req.push_back(mk(bfra_pkg::OP_RESERVE, '1, 32'd1, 2'd0, 48'd0, 9'd0));
      dir_typed.push_back(1'b1); dir_rsp.push_back(status_only(bfra_pkg::ST_TOO_LARGE));
      dir_req.push_back(mk(bfra_pkg::OP_RESERVE, 40'd0, 32'd1, 2'd0, '1, 9'h1FF));
      dir_req.push_back(mk(bfra_pkg::OP_RESERVE, 40'd100, 32'd1, 2'd0, 48'd3, 9'd0));
      dir_req.push_back(mk(bfra_pkg::OP_RESERVE, 40'd5000, 32'd64, 2'd0, 48'd65, 9'd0));
      dir_req.push_back(mk(bfra_pkg::OP_RESERVE, 40'd100, 32'd16, 2'd0, 48'd0, 9'd0));
      dir_req.push_back(mk(bfra_pkg::OP_RESERVE, 40'd5000, 32'd8, 2'd1, 48'd7, 9'd0));
      dir_req.push_back(mk(bfra_pkg::OP_RESERVE, 40'd5000, 32'd4096, 2'd2, 48'd1, 9'd0));
      dir_req.push_back(mk(bfra_pkg::OP_RESERVE, 40'd7, 32'hFFFF_FFFF, 2'd3, '1, 9'd0));
      dir_req.push_back(mk(bfra_pkg::OP_RESERVE, '1, 32'd1, 2'd1, 48'h8000_0000_0000,
                           9'd0));
      dir_req.push_back(mk(bfra_pkg::OP_RESERVE, 40'd1, 32'h8000_0000, 2'd2, 48'd0, 9'd0));
      // a large reuse of one region, then a coarse alignment that reaches the region's end
      dir_req.push_back(mk(bfra_pkg::OP_RESERVE, 40'd2000000, 32'd1, 2'd0, 48'd0, 9'd0));
      dir_req.push_back(mk(bfra_pkg::OP_RESERVE, 40'd10, 32'd1048576, 2'd0, 48'd0, 9'd0));
      dir_req.push_back(mk(bfra_pkg::OP_FREE, '0, '0, '0, '0, 9'd2));
      dir_req.push_back(mk(bfra_pkg::OP_FREE, '0, '0, '0, '0, 9'd3));
      dir_req.push_back(mk(bfra_pkg::OP_FREE, '0, '0, '0, '0, 9'd1));
      dir_req.push_back(mk(bfra_pkg::OP_FREE, '0, '0, '0, '0, 9'd1));
      dir_req.push_back(mk(bfra_pkg::OP_FREE, '0, '0, '0, '0, 9'h1FF));
      while (dir_typed.size() < dir_req.size()) begin
         dir_typed.push_back(1'b0);
         dir_rsp.push_back('0);
      end
      foreach (dir_req[i]) send_word(dir_req[i], dir_typed[i], dir_rsp[i]);
      wait_idle();
      free_all();

      for (int ph = 0; ph < 4; ph++) begin
         wait_idle();
         write_reg(bfra_pkg::CSR_SMALL_PAGE, small_set[ph]);
         write_reg(bfra_pkg::CSR_HUGE_PAGE, huge_set[ph]);
         for (int k = 0; k < 120; k++) begin
            q = random_word();
            send_word(q, 1'b0, '0);
         end
      end

      // fill every slot, then one more reserve runs out of slots
      wait_idle();
      while (live_count() < N)
         send_word(mk(bfra_pkg::OP_RESERVE, 40'($urandom_range(1, 64)), 32'd1, 2'd2,
                      {16'($urandom), 32'($urandom)}, 9'($urandom)), 1'b0, '0);
      send_word(mk(bfra_pkg::OP_RESERVE, 40'd8, 32'd1, 2'd2, 48'd0, 9'd0), 1'b0, '0);

      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0)
         $display("tb_best_fit_region_allocator_unit: done, clean");
      else
         $display("tb_best_fit_region_allocator_unit: done, errors");
      $finish;
   end

endmodule

FILE: best_fit_region_allocator_unit.f
rtl/bfra_pkg.sv
rtl/bfra_rem_unit.sv
rtl/bfra_core.sv
rtl/best_fit_region_allocator_unit.sv
tb/tb_best_fit_region_allocator_unit.sv
